>>> rtl/ssts_pkg.sv
// shared types and codes for the sorted set table
`default_nettype none
package ssts_pkg;

	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 9;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic                       cmp;
		logic                       ins;
		logic                       del;
		logic signed [VALUE_W-1:0]  value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/ssts_cell.sv
// one entry cell: compares against the key and shifts with its neighbors
`default_nettype none
module ssts_cell
	import ssts_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cell_ctrl_t                ctrl,
	input  wire logic [CW-1:0]             count,
	input  wire logic                      prev_less,
	input  wire logic signed [VALUE_W-1:0] prev_entry,
	input  wire logic signed [VALUE_W-1:0] next_entry,
	output logic signed [VALUE_W-1:0]      entry_q,
	output logic                           less_s1,
	output logic                           bnd,
	output logic                           hit
);

	logic eq_s1;
	logic occ;

	assign occ = CW'(INDEX) < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_s1 <= 1'b0;
			eq_s1   <= 1'b0;
		end else if (ctrl.cmp) begin
			less_s1 <= occ && (entry_q < ctrl.value);
			eq_s1   <= occ && (entry_q == ctrl.value);
		end
	end

	assign bnd = prev_less && !less_s1;
	assign hit = bnd && eq_s1;

	// entries beyond the count carry don't-care data
	always_ff @(posedge clk) begin
		if (ctrl.ins && !less_s1) begin
			entry_q <= prev_less ? ctrl.value : prev_entry;
		end else if (ctrl.del && !less_s1) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sorted_set_table.sv
// top level of the sorted set table: cell row, sequencer and output register
`default_nettype none
// Holds up to CAPACITY distinct signed 32-bit values in ascending order, one per
// cell of a row. Each request (find, insert, delete) passes through a compare state,
// in which every cell compares its entry with the key, and an update state, in which
// the row shifts up or down for an insert or delete and the result word is written
// to the output register. A new request is taken in the update state of the previous
// one while the result side keeps up; a stalled result holds the row in its update
// state. No clearing pass is needed after reset.
module sorted_set_table
	import ssts_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // operation[1:0], value[33:2], zero pad
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // status[1:0], position[9:2], entry_count[18:10], zero pad
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	state_t state_q, state_d;

	logic [OP_W-1:0]            op_q;
	logic signed [VALUE_W-1:0]  val_q;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic                       out_valid_q;
	logic [OUT_W-1:0]           out_data_q;

	logic       accept, finish, cmp_en;
	logic       found, ins_commit, del_commit;
	logic [IW-1:0] pos;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0]  pos_out;

	cell_ctrl_t ctrl;

	logic signed [VALUE_W-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0] less, bnd, hit;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		finish   = 1'b0;
		cmp_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_CMP;
			end
			ST_CMP: begin
				cmp_en  = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				finish   = !out_valid_q || m_tready;
				s_tready = finish;
				if (finish) state_d = s_tvalid ? ST_CMP : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tdata[OP_W-1:0];
			val_q <= s_tdata[OP_W +: VALUE_W];
		end
	end

	assign found      = |hit;
	assign ins_commit = finish && (op_q == OP_INSERT) && !found && (cnt_q < CW'(CAPACITY));
	assign del_commit = finish && (op_q == OP_DELETE) && found;

	assign ctrl.cmp   = cmp_en;
	assign ctrl.ins   = ins_commit;
	assign ctrl.del   = del_commit;
	assign ctrl.value = val_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssts_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.count      (cnt_q),
			.prev_less  ((i == 0) ? 1'b1 : less[(i == 0) ? 0 : i-1]),
			.prev_entry ((i == 0) ? val_q : entry[(i == 0) ? 0 : i-1]),
			.next_entry ((i == CAPACITY-1) ? entry[i] : entry[(i == CAPACITY-1) ? i : i+1]),
			.entry_q    (entry[i]),
			.less_s1    (less[i]),
			.bnd        (bnd[i]),
			.hit        (hit[i])
		);
	end

	// boundary is at most one-hot, so an or of masked indices encodes it
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pos = pos | (bnd[i] ? IW'(i) : IW'(0));
		end
	end

	always_comb begin
		cnt_d   = cnt_q;
		status  = STAT_MISS;
		pos_out = '0;
		case (op_q)
			OP_FIND: begin
				if (found) begin
					status  = STAT_DONE;
					pos_out = POS_W'(pos);
				end
			end
			OP_INSERT: begin
				if (found) begin
					status = STAT_MISS;
				end else if (cnt_q >= CW'(CAPACITY)) begin
					status = STAT_FULL;
				end else begin
					status  = STAT_DONE;
					pos_out = POS_W'(pos);
					cnt_d   = cnt_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (found) begin
					status  = STAT_DONE;
					pos_out = POS_W'(pos);
					cnt_d   = cnt_q - 1'b1;
				end
			end
			default: status = STAT_MISS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {{(OUT_W-STAT_W-POS_W-COUNT_W){1'b0}}, COUNT_W'(cnt_d), pos_out, status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $onehot0(hit))
		else $error("more than one cell matched");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_commit |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("insert did not grow the count");

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CMP))
		else $error("accepted word not compared next cycle");

endmodule
`default_nettype wire

>>> test/sorted_set_table_tb.sv
// self-checking testbench for sorted_set_table: directed and random find/insert/delete traffic against a shadow set
`timescale 1ns / 1ps
module sorted_set_table_tb
	import ssts_pkg::*;
;

	localparam int CAP = 256;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
	} set_request_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] entry_count;
	} set_reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	set_request_t request_q[$];
	set_reply_t   expected_replies[$];
	int           known_values[$];

	logic signed [VALUE_W-1:0] held_values[CAP];
	int held_count = 0;

	int errors = 0;
	int accepted = 0;
	int total_requests = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_tick = 0;

	sorted_set_table #(.CAPACITY(CAP)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // operation[1:0], value[33:2], zero pad
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // status[1:0], position[9:2], entry_count[18:10], zero pad
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// shadow of the set, updated in acceptance order
	task automatic apply_request(input logic [1:0] op, input logic signed [VALUE_W-1:0] key);
		set_reply_t r;
		int slot;
		bit hit;
		slot = held_count;
		for (int i = held_count - 1; i >= 0; i--)
			if (held_values[i] >= key)
				slot = i;
		hit = (slot < held_count) && (held_values[slot] == key);
		r.status = STAT_MISS;
		r.position = '0;
		case (op)
			OP_FIND: begin
				if (hit) begin
					r.status = STAT_DONE;
					r.position = slot[POS_W-1:0];
				end
			end
			OP_INSERT: begin
				if (hit) begin
					r.status = STAT_MISS;
				end else if (held_count >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (int i = held_count; i > slot; i--)
						held_values[i] = held_values[i-1];
					held_values[slot] = key;
					held_count++;
					r.status = STAT_DONE;
					r.position = slot[POS_W-1:0];
				end
			end
			OP_DELETE: begin
				if (hit) begin
					for (int i = slot; i < held_count - 1; i++)
						held_values[i] = held_values[i+1];
					held_count--;
					r.status = STAT_DONE;
					r.position = slot[POS_W-1:0];
				end
			end
			default: begin
			end
		endcase
		r.entry_count = held_count[COUNT_W-1:0];
		expected_replies.push_back(r);
	endtask

	task automatic queue_request(input logic [1:0] op, input logic signed [VALUE_W-1:0] value);
		set_request_t q;
		q.op = op;
		q.value = value;
		request_q.push_back(q);
		if (op == OP_INSERT)
			known_values.push_back(value);
	endtask

	function automatic int pick_known();
		return known_values[$urandom_range(0, known_values.size() - 1)];
	endfunction

	function automatic int small_value();
		return int'($urandom_range(0, 64)) - 32;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(s_tdata[1:0], $signed(s_tdata[33:2]));
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (request_q.size() > 0) begin
					set_request_t q;
					q = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, q.value, q.op};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			stall_tick++;
			if (stall_tick % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (stall_tick % 3 == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors++;
			end else begin
				set_reply_t e;
				e = expected_replies.pop_front();
				if (m_tdata[1:0] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[9:2] !== e.position) begin
					$error("position: expected %0d, got %0d", e.position, m_tdata[9:2]);
					errors++;
				end
				if (m_tdata[18:10] !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count, m_tdata[18:10]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int r;
		int v;

		// directed: empty set, extremes, duplicates, misses, spare code
		queue_request(OP_FIND, 0);
		queue_request(OP_DELETE, 5);
		queue_request(OP_SPARE, 7);
		queue_request(OP_INSERT, 32'h7FFF_FFFF);
		queue_request(OP_INSERT, 32'h8000_0000);
		queue_request(OP_INSERT, 0);
		queue_request(OP_INSERT, -1);
		queue_request(OP_INSERT, 1);
		queue_request(OP_INSERT, 0);
		queue_request(OP_INSERT, 32'h7FFF_FFFF);
		queue_request(OP_FIND, 32'h8000_0000);
		queue_request(OP_FIND, 32'h7FFF_FFFF);
		queue_request(OP_FIND, 0);
		queue_request(OP_FIND, 2);
		queue_request(OP_SPARE, 32'h8000_0000);
		queue_request(OP_DELETE, 0);
		queue_request(OP_DELETE, 32'h8000_0000);
		queue_request(OP_DELETE, 32'h7FFF_FFFF);
		queue_request(OP_DELETE, 0);
		queue_request(OP_FIND, -1);
		queue_request(OP_FIND, 1);
		queue_request(OP_INSERT, 32'hFFFF_FFFF);

		// mixed traffic on a narrow range so hits are common
		repeat (120) begin
			r = $urandom_range(0, 19);
			case ($urandom_range(0, 9))
				0: v = pick_known();
				1: v = $urandom;
				default: v = small_value();
			endcase
			if (r < 7)
				queue_request(OP_INSERT, v);
			else if (r < 12)
				queue_request(OP_FIND, v);
			else if (r < 18)
				queue_request(OP_DELETE, v);
			else
				queue_request(OP_SPARE, v);
		end

		// fill to capacity with wide values
		repeat (270) begin
			if ($urandom_range(0, 9) == 0)
				queue_request(OP_FIND, pick_known());
			queue_request(OP_INSERT, $urandom);
		end

		// full set: refused inserts, duplicates and lookups
		repeat (60) begin
			case ($urandom_range(0, 3))
				0: queue_request(OP_INSERT, $urandom);
				1: queue_request(OP_INSERT, pick_known());
				2: queue_request(OP_FIND, pick_known());
				default: queue_request(OP_FIND, $urandom);
			endcase
		end

		// drain
		repeat (160) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				v = $urandom_range(0, known_values.size() - 1);
				queue_request(OP_DELETE, known_values[v]);
				known_values.delete(v);
			end else if (r < 9) begin
				queue_request(OP_FIND, pick_known());
			end else begin
				queue_request(OP_DELETE, $urandom);
			end
		end

		total_requests = request_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < total_requests)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ssts_pkg.sv
rtl/ssts_cell.sv
rtl/sorted_set_table.sv
test/sorted_set_table_tb.sv
